// ===== design/lobm_pkg.sv =====
`timescale 1ns / 1ps
package lobm_pkg;

	localparam int QTY_W   = 32;
	localparam int SIZE_W  = 37;
	localparam int TNUM_W  = 32;
	localparam int ARR_W   = 32;
	localparam int OST_W   = 4;
	localparam int STORE_W = 3;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_MODIFY = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	localparam logic [1:0] TYPE_LIMIT  = 2'd0;
	localparam logic [1:0] TYPE_MARKET = 2'd1;
	localparam logic [1:0] TYPE_IOC    = 2'd2;
	localparam logic [1:0] TYPE_FOK    = 2'd3;

	// stored per-id status
	localparam logic [STORE_W-1:0] ST_UNUSED = 3'd0;
	localparam logic [STORE_W-1:0] ST_NEW    = 3'd1;
	localparam logic [STORE_W-1:0] ST_PART   = 3'd2;
	localparam logic [STORE_W-1:0] ST_FILL   = 3'd3;
	localparam logic [STORE_W-1:0] ST_CANC   = 3'd4;
	localparam logic [STORE_W-1:0] ST_REJ    = 3'd5;

	// reported status
	localparam logic [OST_W-1:0] OUT_NONE    = 4'd0;
	localparam logic [OST_W-1:0] OUT_CANC    = 4'd3;
	localparam logic [OST_W-1:0] OUT_REJ     = 4'd4;
	localparam logic [OST_W-1:0] OUT_UNKNOWN = 4'd5;
	localparam logic [OST_W-1:0] OUT_DUP     = 4'd6;
	localparam logic [OST_W-1:0] OUT_NOTREST = 4'd7;
	localparam logic [OST_W-1:0] OUT_FULL    = 4'd8;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic               load;
		logic               mem_rd;
		logic               clr_step;
		logic               scan_start;
		logic               scan_step;
		logic               size_pass;
		logic               stat_wr;
		logic [STORE_W-1:0] stat_val;
		logic               fill_calc;
		logic               fill_apply;
		logic               rest;
		logic               remove;
		logic               mod_load;
		logic               out_report;
		logic [OST_W-1:0]   rpt_code;
	} cmd_t;

	typedef struct packed {
		logic               clr_last;
		logic               scan_last;
		logic               out_busy;
		logic [1:0]         mode;
		logic [1:0]         otype;
		logic [STORE_W-1:0] stat;
		logic               invalid;
		logic               free_found;
		logic               rest_found;
		logic               fok_short;
		logic               best_found;
		logic               rem_zero;
		logic               rem_full;
		logic               mod_bad;
	} sts_t;

endpackage

// ===== design/lobm_req_if.sv =====
`timescale 1ns / 1ps
interface lobm_req_if #(
	parameter int ORDER_ID_BITS  = 10,
	parameter int TRADER_ID_BITS = 16,
	parameter int PRICE_BITS     = 24
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [ORDER_ID_BITS-1:0]  ord_id;
	logic [TRADER_ID_BITS-1:0] trd_id;
	logic                      side;
	logic [1:0]                order_type;
	logic [PRICE_BITS-1:0]     price_ticks;
	logic [lobm_pkg::QTY_W-1:0] quantity;

	modport source(output valid, mode, ord_id, trd_id, side, order_type,
		price_ticks, quantity, input ready);
	modport sink(input valid, mode, ord_id, trd_id, side, order_type,
		price_ticks, quantity, output ready);
endinterface

// ===== design/lobm_rsp_if.sv =====
`timescale 1ns / 1ps
interface lobm_rsp_if #(
	parameter int ORDER_ID_BITS = 10,
	parameter int PRICE_BITS    = 24
);
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [lobm_pkg::TNUM_W-1:0] trade_number;
	logic [PRICE_BITS-1:0]       trade_price;
	logic [lobm_pkg::QTY_W-1:0]  trade_qty;
	logic [ORDER_ID_BITS-1:0]    taker_id;
	logic [ORDER_ID_BITS-1:0]    maker_id;
	logic [lobm_pkg::OST_W-1:0]  order_state;
	logic [PRICE_BITS-1:0]       top_bid;
	logic [lobm_pkg::SIZE_W-1:0] bid_size;
	logic [PRICE_BITS-1:0]       top_ask;
	logic [lobm_pkg::SIZE_W-1:0] ask_size;
	logic                        last;

	modport source(output valid, kind, trade_number, trade_price, trade_qty, taker_id,
		maker_id, order_state, top_bid, bid_size, top_ask, ask_size, last, input ready);
	modport sink(input valid, kind, trade_number, trade_price, trade_qty, taker_id,
		maker_id, order_state, top_bid, bid_size, top_ask, ask_size, last, output ready);
endinterface

// ===== design/lobm_ctrl.sv =====
`timescale 1ns / 1ps
module lobm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	output logic           ready,
	output lobm_pkg::cmd_t cmd,
	input  lobm_pkg::sts_t sts
);
	import lobm_pkg::*;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_START  = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_DEC    = 4'd5;
	localparam logic [3:0] S_MATCH  = 4'd6;
	localparam logic [3:0] S_FCALC  = 4'd7;
	localparam logic [3:0] S_FEMIT  = 4'd8;
	localparam logic [3:0] S_FINISH = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_MATCH = 2'd1;
	localparam logic [1:0] PH_TOP   = 2'd2;
	localparam logic [1:0] PH_SIZE  = 2'd3;

	logic [3:0]       state_q, state_d;
	logic [1:0]       ph_q, ph_d;
	logic [OST_W-1:0] code_q, code_d;
	logic [STORE_W-1:0] fin_st;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		code_d  = code_q;
		cmd     = '0;
		fin_st  = ST_CANC;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				ph_d       = PH_FIRST;
				state_d    = S_START;
			end
			S_START: begin
				cmd.scan_start = 1'b1;
				cmd.size_pass  = (ph_q == PH_SIZE);
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.size_pass = (ph_q == PH_SIZE);
				if (sts.scan_last) begin
					case (ph_q)
						PH_FIRST: state_d = S_DEC;
						PH_MATCH: state_d = S_MATCH;
						PH_TOP: begin
							ph_d    = PH_SIZE;
							state_d = S_START;
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_DEC: begin
				// default: go report the top of book
				ph_d    = PH_TOP;
				state_d = S_START;
				unique case (sts.mode)
					MODE_ADD: begin
						if (sts.stat != ST_UNUSED) begin
							code_d = OUT_DUP;
						end else begin
							cmd.stat_wr  = 1'b1;
							cmd.stat_val = ST_REJ;
							if (sts.invalid) begin
								code_d = OUT_REJ;
							end else if (sts.otype == TYPE_LIMIT && !sts.free_found) begin
								code_d = OUT_FULL;
							end else if (sts.otype == TYPE_FOK && sts.fok_short) begin
								code_d = OUT_REJ;
							end else begin
								state_d = S_MATCH;
								ph_d    = PH_MATCH;
							end
						end
					end
					MODE_CANCEL: begin
						if (!sts.rest_found) begin
							code_d = OUT_NOTREST;
						end else begin
							cmd.remove   = 1'b1;
							cmd.stat_wr  = 1'b1;
							cmd.stat_val = ST_CANC;
							code_d       = OUT_CANC;
						end
					end
					MODE_MODIFY: begin
						if (!sts.rest_found) begin
							code_d = OUT_NOTREST;
						end else if (sts.mod_bad) begin
							code_d = OUT_REJ;
						end else begin
							// pull the order and re-enter it as a fresh limit add
							cmd.remove   = 1'b1;
							cmd.mod_load = 1'b1;
							ph_d         = PH_FIRST;
						end
					end
					MODE_QUERY: begin
						if (sts.stat == ST_UNUSED || sts.stat > ST_REJ)
							code_d = OUT_UNKNOWN;
						else
							code_d = {1'b0, sts.stat} - 4'd1;
					end
					default: code_d = OUT_UNKNOWN;
				endcase
			end
			S_MATCH: begin
				if (!sts.rem_zero && sts.best_found) state_d = S_FCALC;
				else state_d = S_FINISH;
			end
			S_FCALC: begin
				cmd.fill_calc = 1'b1;
				state_d       = S_FEMIT;
			end
			S_FEMIT: begin
				if (!sts.out_busy) begin
					cmd.fill_apply = 1'b1;
					ph_d           = PH_MATCH;
					state_d        = S_START;
				end
			end
			S_FINISH: begin
				if (sts.rem_zero) begin
					fin_st = ST_FILL;
				end else if (sts.otype == TYPE_LIMIT) begin
					fin_st   = sts.rem_full ? ST_NEW : ST_PART;
					cmd.rest = sts.free_found;
				end
				cmd.stat_wr  = 1'b1;
				cmd.stat_val = fin_st;
				code_d       = {1'b0, fin_st} - 4'd1;
				ph_d         = PH_TOP;
				state_d      = S_START;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.out_report = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.rpt_code = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ph_q    <= PH_FIRST;
			code_q  <= OUT_NONE;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			code_q  <= code_d;
		end
	end

endmodule

// ===== design/lobm_dp.sv =====
`timescale 1ns / 1ps
module lobm_dp #(
	parameter int BOOK_SLOTS     = 32,
	parameter int ORDER_ID_BITS  = 10,
	parameter int PRICE_BITS     = 24,
	parameter int TRADER_ID_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lobm_pkg::cmd_t             cmd,
	output lobm_pkg::sts_t             sts,
	input  logic [1:0]                 in_mode,
	input  logic [ORDER_ID_BITS-1:0]   in_ord_id,
	input  logic [TRADER_ID_BITS-1:0]  in_trd_id,
	input  logic                       in_side,
	input  logic [1:0]                 in_order_type,
	input  logic [PRICE_BITS-1:0]      in_price_ticks,
	input  logic [lobm_pkg::QTY_W-1:0] in_quantity,
	lobm_rsp_if.source                 rsp
);
	import lobm_pkg::*;

	localparam int SLOT_W   = $clog2(BOOK_SLOTS);
	localparam int AVAIL_W  = QTY_W + SLOT_W + 1;
	localparam int ID_COUNT = 1 << ORDER_ID_BITS;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BOOK_SLOTS - 1);

	// request being worked on
	logic [1:0]                mode_q;
	logic [ORDER_ID_BITS-1:0]  id_q;
	logic [TRADER_ID_BITS-1:0] trader_q;
	logic                      side_q;
	logic [1:0]                type_q;
	logic [PRICE_BITS-1:0]     price_q;
	logic [QTY_W-1:0]          qty_q;
	logic [QTY_W-1:0]          rem_q;
	logic [QTY_W-1:0]          fill_q;

	// resting order table
	logic                      valid_q  [BOOK_SLOTS];
	logic [ORDER_ID_BITS-1:0]  order_q  [BOOK_SLOTS];
	logic [TRADER_ID_BITS-1:0] strader_q[BOOK_SLOTS];
	logic                      sside_q  [BOOK_SLOTS];
	logic [PRICE_BITS-1:0]     sprice_q [BOOK_SLOTS];
	logic [QTY_W-1:0]          sremain_q[BOOK_SLOTS];
	logic [ARR_W-1:0]          sarr_q   [BOOK_SLOTS];

	// per-id status memory
	logic [STORE_W-1:0]        stat_mem [ID_COUNT];
	logic [STORE_W-1:0]        stat_q;
	logic [ORDER_ID_BITS-1:0]  clr_cnt_q;
	logic                      mem_we;
	logic [ORDER_ID_BITS-1:0]  mem_wa;
	logic [STORE_W-1:0]        mem_wd;

	// scan accumulators
	logic [SLOT_W-1:0]         cnt_q;
	logic                      best_found_q;
	logic [SLOT_W-1:0]         best_idx_q;
	logic [PRICE_BITS-1:0]     best_pr_q;
	logic [QTY_W-1:0]          best_rm_q;
	logic [ORDER_ID_BITS-1:0]  best_oid_q;
	logic [ARR_W-1:0]          best_age_q;
	logic                      free_found_q;
	logic [SLOT_W-1:0]         free_idx_q;
	logic                      rest_found_q;
	logic [SLOT_W-1:0]         rest_idx_q;
	logic [TRADER_ID_BITS-1:0] rest_trader_q;
	logic                      rest_side_q;
	logic [AVAIL_W-1:0]        avail_q;
	logic                      hb_q, ha_q;
	logic [PRICE_BITS-1:0]     bb_q, ba_q;
	logic [SIZE_W-1:0]         bid_sz_q, ask_sz_q;

	logic [TNUM_W-1:0]         next_trade_q;
	logic [ARR_W-1:0]          arr_ctr_q;

	// output register
	logic                      out_v_q;
	logic                      kind_q;
	logic [TNUM_W-1:0]         tnum_q;
	logic [PRICE_BITS-1:0]     tprice_q;
	logic [QTY_W-1:0]          tqty_q;
	logic [ORDER_ID_BITS-1:0]  taker_q;
	logic [ORDER_ID_BITS-1:0]  maker_q;
	logic [OST_W-1:0]          ost_q;
	logic [PRICE_BITS-1:0]     obb_q, oba_q;
	logic [SIZE_W-1:0]         obs_q, oas_q;
	logic                      olast_q;

	// slot under scan
	logic                      s_v, s_sd, s_elig, s_better, s_fill_out;
	logic [PRICE_BITS-1:0]     s_pr;
	logic [QTY_W-1:0]          s_rm;
	logic [ARR_W-1:0]          s_age;

	assign s_v  = valid_q[cnt_q];
	assign s_sd = sside_q[cnt_q];
	assign s_pr = sprice_q[cnt_q];
	assign s_rm = sremain_q[cnt_q];
	assign s_age = arr_ctr_q - sarr_q[cnt_q];

	always_comb begin
		s_elig = s_v && (s_sd != side_q) && (strader_q[cnt_q] != trader_q);
		if (type_q != TYPE_MARKET)
			s_elig = s_elig && (side_q ? (s_pr >= price_q) : (s_pr <= price_q));
		if (!best_found_q)
			s_better = 1'b1;
		else if (s_pr != best_pr_q)
			s_better = side_q ? (s_pr > best_pr_q) : (s_pr < best_pr_q);
		else
			s_better = s_age > best_age_q;
	end

	assign s_fill_out = (best_rm_q == fill_q);

	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_cnt_q == {ORDER_ID_BITS{1'b1}});
		sts.scan_last  = (cnt_q == LAST_SLOT);
		sts.out_busy   = out_v_q && !rsp.ready;
		sts.mode       = mode_q;
		sts.otype      = type_q;
		sts.stat       = stat_q;
		sts.invalid    = (id_q == '0) || (qty_q == '0) ||
			(type_q != TYPE_MARKET && price_q == '0);
		sts.free_found = free_found_q;
		sts.rest_found = rest_found_q;
		sts.fok_short  = avail_q < AVAIL_W'(qty_q);
		sts.best_found = best_found_q;
		sts.rem_zero   = (rem_q == '0);
		sts.rem_full   = (rem_q == qty_q);
		sts.mod_bad    = (price_q == '0) || (qty_q == '0);
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			id_q     <= in_ord_id;
			trader_q <= in_trd_id;
			side_q   <= in_side;
			type_q   <= in_order_type;
			price_q  <= in_price_ticks;
			qty_q    <= in_quantity;
			rem_q    <= in_quantity;
		end else if (cmd.mod_load) begin
			mode_q   <= MODE_ADD;
			trader_q <= rest_trader_q;
			side_q   <= rest_side_q;
			type_q   <= TYPE_LIMIT;
		end else if (cmd.fill_apply) begin
			rem_q    <= rem_q - fill_q;
		end
		if (cmd.fill_calc)
			fill_q <= (rem_q < best_rm_q) ? rem_q : best_rm_q;
	end

	// status memory with registered read
	always_comb begin
		mem_we = cmd.clr_step || cmd.stat_wr || cmd.fill_apply;
		if (cmd.clr_step) begin
			mem_wa = clr_cnt_q;
			mem_wd = ST_UNUSED;
		end else if (cmd.fill_apply) begin
			mem_wa = best_oid_q;
			mem_wd = s_fill_out ? ST_FILL : ST_PART;
		end else begin
			mem_wa = id_q;
			mem_wd = cmd.stat_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			stat_mem[mem_wa] <= mem_wd;
		if (cmd.mod_load)
			stat_q <= ST_UNUSED;
		else if (cmd.mem_rd)
			stat_q <= stat_mem[id_q];
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BOOK_SLOTS; i++)
				valid_q[i] <= 1'b0;
		end else begin
			if (cmd.fill_apply && s_fill_out)
				valid_q[best_idx_q] <= 1'b0;
			if (cmd.remove)
				valid_q[rest_idx_q] <= 1'b0;
			if (cmd.rest)
				valid_q[free_idx_q] <= 1'b1;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (cmd.fill_apply)
			sremain_q[best_idx_q] <= best_rm_q - fill_q;
		if (cmd.rest) begin
			order_q[free_idx_q]   <= id_q;
			strader_q[free_idx_q] <= trader_q;
			sside_q[free_idx_q]   <= side_q;
			sprice_q[free_idx_q]  <= price_q;
			sremain_q[free_idx_q] <= rem_q;
			sarr_q[free_idx_q]    <= arr_ctr_q;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			next_trade_q <= TNUM_W'(1);
			arr_ctr_q    <= '0;
		end else begin
			if (cmd.clr_step)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.fill_apply)
				next_trade_q <= next_trade_q + 1'b1;
			if (cmd.rest)
				arr_ctr_q <= arr_ctr_q + 1'b1;
		end
	end

	// one slot per cycle: best maker, free slot, resting id, top of book, sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			rest_found_q <= 1'b0;
			hb_q         <= 1'b0;
			ha_q         <= 1'b0;
			bb_q         <= '0;
			ba_q         <= '0;
			avail_q      <= '0;
			bid_sz_q     <= '0;
			ask_sz_q     <= '0;
		end else if (cmd.scan_start) begin
			cnt_q <= '0;
			if (cmd.size_pass) begin
				bid_sz_q <= '0;
				ask_sz_q <= '0;
			end else begin
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
				rest_found_q <= 1'b0;
				hb_q         <= 1'b0;
				ha_q         <= 1'b0;
				bb_q         <= '0;
				ba_q         <= '0;
				avail_q      <= '0;
			end
		end else if (cmd.scan_step) begin
			cnt_q <= (cnt_q == LAST_SLOT) ? '0 : cnt_q + 1'b1;
			if (cmd.size_pass) begin
				if (s_v && !s_sd && s_pr == bb_q)
					bid_sz_q <= bid_sz_q + SIZE_W'(s_rm);
				if (s_v && s_sd && s_pr == ba_q)
					ask_sz_q <= ask_sz_q + SIZE_W'(s_rm);
			end else begin
				if (s_elig) begin
					avail_q <= avail_q + AVAIL_W'(s_rm);
					if (s_better) begin
						best_found_q <= 1'b1;
						best_idx_q   <= cnt_q;
						best_pr_q    <= s_pr;
						best_rm_q    <= s_rm;
						best_oid_q   <= order_q[cnt_q];
						best_age_q   <= s_age;
					end
				end
				if (!s_v && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cnt_q;
				end
				if (s_v && order_q[cnt_q] == id_q && !rest_found_q) begin
					rest_found_q  <= 1'b1;
					rest_idx_q    <= cnt_q;
					rest_trader_q <= strader_q[cnt_q];
					rest_side_q   <= s_sd;
				end
				if (s_v && !s_sd && (!hb_q || s_pr > bb_q)) begin
					hb_q <= 1'b1;
					bb_q <= s_pr;
				end
				if (s_v && s_sd && (!ha_q || s_pr < ba_q)) begin
					ha_q <= 1'b1;
					ba_q <= s_pr;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.fill_apply || cmd.out_report)
			out_v_q <= 1'b1;
		else if (rsp.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_apply) begin
			kind_q   <= KIND_TRADE;
			tnum_q   <= next_trade_q;
			tprice_q <= best_pr_q;
			tqty_q   <= fill_q;
			taker_q  <= id_q;
			maker_q  <= best_oid_q;
			ost_q    <= OUT_NONE;
			obb_q    <= '0;
			obs_q    <= '0;
			oba_q    <= '0;
			oas_q    <= '0;
			olast_q  <= 1'b0;
		end else if (cmd.out_report) begin
			kind_q   <= KIND_REPORT;
			tnum_q   <= '0;
			tprice_q <= '0;
			tqty_q   <= '0;
			taker_q  <= id_q;
			maker_q  <= '0;
			ost_q    <= cmd.rpt_code;
			obb_q    <= bb_q;
			obs_q    <= bid_sz_q;
			oba_q    <= ba_q;
			oas_q    <= ask_sz_q;
			olast_q  <= 1'b1;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.kind         = kind_q;
	assign rsp.trade_number = tnum_q;
	assign rsp.trade_price  = tprice_q;
	assign rsp.trade_qty    = tqty_q;
	assign rsp.taker_id     = taker_q;
	assign rsp.maker_id     = maker_q;
	assign rsp.order_state  = ost_q;
	assign rsp.top_bid      = obb_q;
	assign rsp.bid_size     = obs_q;
	assign rsp.top_ask      = oba_q;
	assign rsp.ask_size     = oas_q;
	assign rsp.last         = olast_q;

endmodule

// ===== design/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// Price-time priority order book over a table of BOOK_SLOTS resting orders.
// req channel: one request per transaction (add, cancel, modify, query).
// rsp channel: zero or more trade records (kind 0), then one final report
// (kind 1, last 1) with the status and the top of book.
// Each request walks the table one slot per cycle in passes: one lookup
// pass, then two passes for the top of book (best prices, then sizes). An
// add that goes to matching adds one rescan after each fill, and a valid
// modify adds a second lookup pass; output stalls lengthen a request.
// req.ready is high only while no request is in progress; the next request
// is taken as soon as the final report sits in the output register.
// The output register holds one result; while rsp.ready is low the block
// waits before placing the next result and nothing is lost.
// After reset the per-id status memory is cleared, one entry a cycle, with
// req.ready low; the book starts empty and the trade number at one.
module limit_order_book_matcher #(
	parameter int BOOK_SLOTS     = 32,
	parameter int ORDER_ID_BITS  = 10,
	parameter int PRICE_BITS     = 24,
	parameter int TRADER_ID_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lobm_req_if.sink   req,
	lobm_rsp_if.source rsp
);
	import lobm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ctrl_ready;
	logic in_fire;

	assign req.ready = ctrl_ready;
	assign in_fire   = req.valid && ctrl_ready;

	lobm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.ready   (ctrl_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	lobm_dp #(
		.BOOK_SLOTS     (BOOK_SLOTS),
		.ORDER_ID_BITS  (ORDER_ID_BITS),
		.PRICE_BITS     (PRICE_BITS),
		.TRADER_ID_BITS (TRADER_ID_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_mode        (req.mode),
		.in_ord_id      (req.ord_id),
		.in_trd_id      (req.trd_id),
		.in_side        (req.side),
		.in_order_type  (req.order_type),
		.in_price_ticks (req.price_ticks),
		.in_quantity    (req.quantity),
		.rsp            (rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in progress");

	a_trade_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_TRADE |-> rsp.trade_qty != '0 && !rsp.last)
		else $error("empty fill or trade marked last");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_REPORT |-> rsp.last && rsp.trade_qty == '0)
		else $error("final report malformed");

endmodule
